/* hw/rtl/wls_pkg.sv */
// Shared types and constants for the wear-levelling ring store.
package wls_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned STATUS_W = 8;
  localparam int unsigned ADDR_W   = 16;

  localparam logic KIND_LOCATE = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;
    logic scan_start;
    logic scan_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

/* hw/rtl/wls_if.sv */
// Valid/ready channel interfaces for input words and result words.
interface wls_in_if;
  import wls_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output kind, output write_data, input ready);
  modport sink (input valid, input kind, input write_data, output ready);
endinterface

interface wls_out_if;
  import wls_pkg::*;
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   current_address;
  logic [STATUS_W-1:0] current_status;

  modport source (output valid, output current_address, output current_status,
                  input ready);
  modport sink (input valid, input current_address, input current_status,
                output ready);
endinterface

/* hw/rtl/wls_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module wls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/wls_ctrl.sv */
// Controller: handshakes, scan sequencing and the result valid flag.
module wls_ctrl import wls_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        // A new word is taken only when the result slot is free at this edge.
        in_ready = !out_valid || out_ready;
        if (in_valid && in_ready) begin
          if (in_kind == KIND_WRITE) begin
            cmd.write    = 1'b1;
            cmd.load_out = 1'b1;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

/* hw/rtl/wls_dp.sv */
// Datapath: ring memories, entry valid bits, index, scan compare, result.
module wls_dp import wls_pkg::*; #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [ADDR_W-1:0]   cfg_wdata,
  input  logic [DATA_W-1:0]   write_data,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic [ADDR_W-1:0]   current_address,
  output logic [STATUS_W-1:0] current_status
);

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  logic [ADDR_W-1:0]     buffer_base;
  logic [IDX_W-1:0]      cur_index;
  logic [STATUS_W-1:0]   cur_status;
  logic [RING_DEPTH-1:0] valid;
  logic [IDX_W-1:0]      pos;
  logic [STATUS_W-1:0]   prev;
  logic                  rd_valid;

  logic [IDX_W-1:0]    wr_index;
  logic [STATUS_W-1:0] wr_status;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic [STATUS_W-1:0] rd_data;
  logic [STATUS_W-1:0] scan_stat;
  logic                scan_match;
  logic [IDX_W-1:0]    res_index;
  logic [STATUS_W-1:0] res_status;

  // cur_status always mirrors the status stored at cur_index, so a write
  // needs no read of the status ring.
  assign wr_index  = (cur_index == LAST_IDX) ? '0 : cur_index + 1'b1;
  assign wr_status = cur_status + 8'd1;

  // An entry never written since reset reads as zero.
  assign scan_stat     = rd_valid ? rd_data : '0;
  assign scan_match    = (pos == '0) || (scan_stat == prev + 8'd1);
  assign sts.scan_last = !scan_match || (pos == LAST_IDX);

  assign rd_en   = cmd.scan_start || (cmd.scan_step && !sts.scan_last);
  assign rd_addr = cmd.scan_start ? '0 : pos + 1'b1;

  always_comb begin
    if (cmd.write) begin
      res_index  = wr_index;
      res_status = wr_status;
    end else if (scan_match) begin
      res_index  = pos;
      res_status = scan_stat;
    end else begin
      res_index  = pos - 1'b1;
      res_status = prev;
    end
  end

  wls_ram #(.WIDTH(STATUS_W), .DEPTH(RING_DEPTH)) u_status_ram (
    .clk     (clk),
    .wr_en   (cmd.write),
    .wr_addr (wr_index),
    .wr_data (wr_status),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wls_ram #(.WIDTH(DATA_W), .DEPTH(RING_DEPTH)) u_value_ram (
    .clk     (clk),
    .wr_en   (cmd.write),
    .wr_addr (wr_index),
    .wr_data (write_data),
    .rd_en   (1'b0),
    .rd_addr ('0),
    .rd_data ()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_base <= '0;
      cur_index   <= '0;
      cur_status  <= '0;
      valid       <= '0;
    end else begin
      if (cfg_we) begin
        buffer_base <= cfg_wdata;
      end
      if (cmd.write) begin
        valid[wr_index] <= 1'b1;
      end
      if (cmd.load_out) begin
        cur_index  <= res_index;
        cur_status <= res_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_valid <= valid[rd_addr];
    end
    if (cmd.scan_start) begin
      pos <= '0;
    end else if (cmd.scan_step) begin
      prev <= scan_stat;
      if (!sts.scan_last) begin
        pos <= pos + 1'b1;
      end
    end
    if (cmd.load_out) begin
      current_address <= buffer_base + ADDR_W'(res_index);
      current_status  <= res_status;
    end
  end

endmodule

/* hw/rtl/wear_levelling_ring_store.sv */
// Top level of the wear-levelling ring store: controller plus datapath.
//
//   Channel  Direction  Payload                           Handshake
//   item     in         kind, write_data                  valid / ready
//   result   out        current_address, current_status   valid / ready
//   cfg      in         cfg_wdata (buffer_base)           cfg_we, no wait
//
// A write word finishes at its accepting edge and its result word is valid in
// the next cycle, so writes sustain one word per cycle while results are taken.
// A locate word walks the status ring one entry per cycle through the status
// RAM read port, and its result word is registered when the walk stops at the
// first entry that breaks the run of statuses or at the last entry.
// Reset clears the index, the buffer base and the per-entry valid bits; an
// entry not yet written reads as zero, so no clearing pass is needed.
// A new word is accepted only when the block is idle and the result register
// is empty or being emptied in that same cycle.
module wear_levelling_ring_store import wls_pkg::*; #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  wls_in_if.sink            item,
  wls_out_if.source         result,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  // Command and status between the controller and the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller owns the handshakes and the sequencing of a locate scan.
  wls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_kind   (item.kind),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds both rings, the current index and the result register.
  wls_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .write_data      (item.write_data),
    .cmd             (cmd),
    .sts             (sts),
    .current_address (result.current_address),
    .current_status  (result.current_status)
  );

endmodule

/* sim/wear_levelling_ring_store_checker.sv */
// Checker that mirrors the ring store and compares every result word it sends.
`timescale 1ns / 1ps
module wear_levelling_ring_store_checker import wls_pkg::*; #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_ready,
  input  logic                item_kind,
  input  logic [DATA_W-1:0]   item_data,
  input  logic                result_valid,
  input  logic                result_ready,
  input  logic [ADDR_W-1:0]   result_address,
  input  logic [STATUS_W-1:0] result_status,
  input  logic                cfg_we,
  input  logic [ADDR_W-1:0]   cfg_wdata,
  output int                  mismatch_count,
  output int                  words_awaited
);

  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic [STATUS_W-1:0] status;
  } ring_position_t;

  ring_position_t      awaited_positions[$];
  logic [ADDR_W-1:0]   base_copy;
  logic [DATA_W-1:0]   value_copy[RING_DEPTH];
  logic [STATUS_W-1:0] status_copy[RING_DEPTH];
  int unsigned         index_copy;

  // Applies one word to the mirrored rings and returns the position it leaves.
  function automatic ring_position_t advance_ring(input logic kind,
                                                  input logic [DATA_W-1:0] data);
    ring_position_t      landed;
    int unsigned         run_end;
    logic [STATUS_W-1:0] next_status;
    if (kind == KIND_LOCATE) begin
      run_end = 0;
      while (run_end + 1 < RING_DEPTH) begin
        next_status = status_copy[run_end] + 1'b1;
        if (status_copy[run_end + 1] != next_status) break;
        run_end++;
      end
      index_copy = run_end;
    end else begin
      next_status = status_copy[index_copy] + 1'b1;
      index_copy = (index_copy + 1 == RING_DEPTH) ? 0 : index_copy + 1;
      value_copy[index_copy] = data;
      status_copy[index_copy] = next_status;
    end
    landed.address = base_copy + ADDR_W'(index_copy);
    landed.status = status_copy[index_copy];
    return landed;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    ring_position_t want;
    if (rst) begin
      awaited_positions.delete();
      mismatch_count = 0;
      base_copy = '0;
      index_copy = 0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        value_copy[i] = '0;
        status_copy[i] = '0;
      end
    end else begin
      if (cfg_we) base_copy = cfg_wdata;
      // A result can never belong to a word accepted at the same edge.
      if (result_valid && result_ready) begin
        if (awaited_positions.size() == 0) begin
          report_mismatch($sformatf("result word %h/%h with nothing awaited",
                                    result_address, result_status));
        end else begin
          want = awaited_positions.pop_front();
          if (result_address !== want.address)
            report_mismatch($sformatf("current_address expected %h, got %h",
                                      want.address, result_address));
          if (result_status !== want.status)
            report_mismatch($sformatf("current_status expected %h, got %h",
                                      want.status, result_status));
        end
      end
      if (item_valid && item_ready)
        awaited_positions.push_back(advance_ring(item_kind, item_data));
    end
    words_awaited <= awaited_positions.size();
  end

endmodule

/* sim/wear_levelling_ring_store_tb.sv */
// Testbench top: drives words and the base register into the ring store.
`timescale 1ns / 1ps
module wear_levelling_ring_store_tb;
  import wls_pkg::*;

  localparam int unsigned RING_DEPTH      = 16;
  // A locate walks the whole ring at worst, one entry per cycle.
  localparam int unsigned SCAN_CYCLES     = RING_DEPTH + 1;
  localparam int unsigned WORDS_PER_PHASE = 216;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;
  logic              sink_ready = 1'b0;
  logic              quiet_source = 1'b0;
  logic              quiet_sink = 1'b0;
  int                sink_stall = 0;
  int                sink_gap;
  int                mismatch_count;
  int                words_awaited;

  wls_in_if  item_ch ();
  wls_out_if result_ch ();

  assign result_ch.ready = sink_ready;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  wear_levelling_ring_store #(
    .RING_DEPTH(RING_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  wear_levelling_ring_store_checker #(
    .RING_DEPTH(RING_DEPTH)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_ch.valid),
    .item_ready    (item_ch.ready),
    .item_kind     (item_ch.kind),
    .item_data     (item_ch.write_data),
    .result_valid  (result_ch.valid),
    .result_ready  (result_ch.ready),
    .result_address(result_ch.current_address),
    .result_status (result_ch.current_status),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_count),
    .words_awaited (words_awaited)
  );

  // Most idle stretches are short; now and then one is long
  // enough to cover a whole locate scan and more.
  function automatic int idle_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The result side stalls at random unless a quiet stretch is running.
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      sink_stall <= 0;
    end else if (sink_stall > 0) begin
      sink_ready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else begin
      sink_gap = (!quiet_sink && $urandom_range(0, 3) == 0) ? idle_length() : 0;
      sink_ready <= (sink_gap == 0);
      sink_stall <= (sink_gap > 0) ? sink_gap - 1 : 0;
    end
  end

  // Offers one word, after an optional idle stretch, and returns at the edge
  // that accepts it. Valid stays high between back-to-back words, so it is
  // only lowered when a gap actually follows.
  task automatic send_word(input logic kind, input logic [DATA_W-1:0] data);
    int gap;
    gap = (!quiet_source && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.kind       <= kind;
    item_ch.write_data <= data;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Stops offering words and waits until every awaited result has arrived.
  // The count from the checker is registered, hence the first wait.
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_awaited != 0) @(posedge clk);
  endtask

  // Every word yields a result, so a drained block is an idle block and the
  // base register can be written right away.
  task automatic write_base(input logic [ADDR_W-1:0] base);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly writes, as in use, with locates sprinkled in, sometimes several in
  // a row. The long write runs carry the status counters across 255 to 0.
  task automatic run_random_phase(input logic [ADDR_W-1:0] base);
    int sent;
    int burst;
    write_base(base);
    sent = 0;
    while (sent < WORDS_PER_PHASE) begin
      if (sent % 40 == 0) begin
        quiet_source = ($urandom_range(0, 3) == 0);
        quiet_sink   = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 3);
        repeat (burst) begin
          send_word(KIND_LOCATE, DATA_W'($urandom));
          sent++;
        end
      end else begin
        send_word(KIND_WRITE, DATA_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    item_ch.valid      <= 1'b0;
    item_ch.kind       <= KIND_LOCATE;
    item_ch.write_data <= '0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the base at its top so that the address wraps.
    write_base(16'hFFFF);
    // A locate on the freshly cleared ring lands on entry 0.
    send_word(KIND_LOCATE, 8'hFF);
    // Fifteen writes give statuses 0..15 across the ring, one unbroken run.
    for (int i = 0; i < 15; i++)
      send_word(KIND_WRITE, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : DATA_W'(i * 17));
    // The scan now runs to the end of the ring.
    send_word(KIND_LOCATE, 8'h00);
    // Wrapping to entry 0 breaks the run right after it.
    send_word(KIND_WRITE, 8'hFF);
    send_word(KIND_LOCATE, 8'h00);
    send_word(KIND_WRITE, 8'h00);
    send_word(KIND_LOCATE, 8'hFF);
    send_word(KIND_LOCATE, 8'h00);
    // A rewrite of the same byte still advances the status.
    send_word(KIND_WRITE, 8'h00);
    send_word(KIND_WRITE, 8'h00);
    send_word(KIND_LOCATE, 8'h5A);

    // Random part over several base settings, zero and one near the top among them.
    run_random_phase(16'h0000);
    run_random_phase(ADDR_W'($urandom));
    run_random_phase(16'h8000);
    run_random_phase(16'hFFF8);
    run_random_phase(ADDR_W'($urandom));

    wait_drained();
    // Leave room for any stray result word to show up.
    repeat (2 * SCAN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("wear_levelling_ring_store verification clean");
    end else begin
      $display("wear_levelling_ring_store verification failed");
    end
    $finish;
  end

  // Hard stop, several times the slowest legal run.
  initial begin
    #1_000_000;
    $display("wear_levelling_ring_store verification failed");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/wls_pkg.sv
hw/rtl/wls_if.sv
hw/rtl/wls_ram.sv
hw/rtl/wls_ctrl.sv
hw/rtl/wls_dp.sv
hw/rtl/wear_levelling_ring_store.sv
sim/wear_levelling_ring_store_checker.sv
sim/wear_levelling_ring_store_tb.sv
